// ----- src/ca3d_pkg.sv -----
// shared types and constants for the 3-d cellular automaton step block
// no dependencies; used by cellular_automaton_3d_step
package ca3d_pkg;

  localparam int MAX_SIDE_DEF = 16;

  typedef enum logic [1:0] {
    OP_WRITE    = 2'd0,
    OP_READ     = 2'd1,
    OP_STEP     = 2'd2,
    OP_RESERVED = 2'd3
  } op_t;

  localparam logic [1:0] REG_NUM_STATES   = 2'd0;
  localparam logic [1:0] REG_SURVIVAL     = 2'd1;
  localparam logic [1:0] REG_SPAWN        = 2'd2;
  localparam logic [1:0] REG_GRID_SIDE    = 2'd3;

  localparam logic [4:0]  NUM_STATES_RST = 5'd5;
  localparam logic [26:0] SURVIVAL_RST   = 27'd16;
  localparam logic [26:0] SPAWN_RST      = 27'd16;
  localparam logic [4:0]  GRID_SIDE_RST  = 5'd16;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RDWAIT,
    ST_STEP,
    ST_STEP_DRAIN,
    ST_COPY,
    ST_COPY_DRAIN,
    ST_FINISH
  } state_t;

endpackage

// ----- src/cellular_automaton_3d_step.sv -----
// top level: cubic grid of 4-bit cells held in a cell memory and a scratch memory
// depends on ca3d_pkg
// a step reads 27 cells per cell (the cell and its 26 neighbors) on the single cell
// memory read port, then copies every cell from the scratch memory back to the
// cell memory; one item in flight at a time
// reset: synchronous; a clearing pass over all MAX_SIDE^3 cells zeroes the cell memory
// while in_tready stays low, configuration writes are taken throughout
module cellular_automaton_3d_step #(
  parameter int MAX_SIDE = ca3d_pkg::MAX_SIDE_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // pos_x, pos_y, pos_z, health_in
  input  logic [1:0]  in_tuser,   // operation
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // health_out, zero fill
  output logic [1:0]  out_tuser,  // step_done, out_of_range
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [26:0] cfg_data
);

  localparam int DEPTH = MAX_SIDE * MAX_SIDE * MAX_SIDE;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(MAX_SIDE);
  localparam int SW    = $clog2(MAX_SIDE + 1);

  ca3d_pkg::state_t state_r, state_nxt;

  logic [4:0]  num_states_r;
  logic [26:0] survival_r;
  logic [26:0] spawn_r;
  logic [4:0]  grid_side_r;

  logic        out_valid_r;
  logic [3:0]  out_health_r;
  logic        out_done_r, out_oor_r;
  logic        out_load;
  logic [3:0]  out_health_nxt;
  logic        out_done_nxt, out_oor_nxt;

  logic [AW-1:0] clr_addr_r, clr_addr_nxt;
  logic [CW-1:0] cx_r, cy_r, cz_r, cx_nxt, cy_nxt, cz_nxt;
  logic [1:0]    dx_r, dy_r, dz_r, dx_nxt, dy_nxt, dz_nxt;

  logic          tag_valid_r, tag_first_r, tag_center_r, tag_last_r;
  logic          tag_valid_nxt, tag_first_nxt, tag_center_nxt, tag_last_nxt;
  logic [AW-1:0] tag_addr_r, tag_addr_nxt;
  logic [4:0]    cnt_r;
  logic [3:0]    hp_r;

  logic          cp_valid_r, cp_valid_nxt;
  logic [AW-1:0] cp_addr_r, cp_addr_nxt;

  logic [3:0] cell_mem [DEPTH];
  logic [3:0] next_mem [DEPTH];
  logic [3:0] rd_data_r, nx_data_r;

  logic          cm_re, cm_we, nm_re;
  logic [AW-1:0] cm_raddr, cm_waddr, nm_raddr;
  logic [3:0]    cm_wdata;

  logic [SW-1:0] side_u;
  logic [CW-1:0] smax;
  logic [3:0]    full_v;
  logic [3:0]    pos_x, pos_y, pos_z, health_in, health_clamp;
  ca3d_pkg::op_t op;
  logic          out_free, in_fire, oor, last_cell, last_k;
  logic [AW-1:0] pos_addr, cell_addr_c, nb_addr;
  logic          is_full;
  logic [4:0]    cnt_fin;
  logic [3:0]    nv;

  function automatic logic [AW-1:0] cell_addr(input logic [CW-1:0] x,
                                              input logic [CW-1:0] y,
                                              input logic [CW-1:0] z);
    cell_addr = AW'(x) + AW'(MAX_SIDE) * AW'(y) + AW'(MAX_SIDE * MAX_SIDE) * AW'(z);
  endfunction

  function automatic logic [CW-1:0] wrap(input logic [CW-1:0] c, input logic [1:0] d,
                                         input logic [CW-1:0] m);
    if (d == 2'd0) begin
      wrap = (c == '0) ? m : c - 1'b1;
    end else if (d == 2'd2) begin
      wrap = (c == m) ? '0 : c + 1'b1;
    end else begin
      wrap = c;
    end
  endfunction

  // used grid side and full value, saturated
  always_comb begin
    if (grid_side_r == 5'd0) begin
      side_u = SW'(1);
    end else if (8'(grid_side_r) > 8'(MAX_SIDE)) begin
      side_u = SW'(MAX_SIDE);
    end else begin
      side_u = SW'(grid_side_r);
    end
    if (num_states_r < 5'd2) begin
      full_v = 4'd1;
    end else if (num_states_r > 5'd16) begin
      full_v = 4'd15;
    end else begin
      full_v = 4'(num_states_r - 5'd1);
    end
  end

  assign smax      = CW'(side_u - 1'b1);
  assign pos_x     = in_tdata[3:0];
  assign pos_y     = in_tdata[7:4];
  assign pos_z     = in_tdata[11:8];
  assign health_in = in_tdata[15:12];
  assign op        = ca3d_pkg::op_t'(in_tuser);
  assign oor       = ((SW + 4)'(pos_x) >= (SW + 4)'(side_u)) ||
                     ((SW + 4)'(pos_y) >= (SW + 4)'(side_u)) ||
                     ((SW + 4)'(pos_z) >= (SW + 4)'(side_u));
  assign health_clamp = (health_in > full_v) ? full_v : health_in;
  assign pos_addr  = cell_addr(CW'(pos_x), CW'(pos_y), CW'(pos_z));
  assign cell_addr_c = cell_addr(cx_r, cy_r, cz_r);
  assign nb_addr   = cell_addr(wrap(cx_r, dx_r, smax), wrap(cy_r, dy_r, smax),
                               wrap(cz_r, dz_r, smax));
  assign last_cell = (cx_r == smax) && (cy_r == smax) && (cz_r == smax);
  assign last_k    = (dx_r == 2'd2) && (dy_r == 2'd2) && (dz_r == 2'd2);

  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (state_r == ca3d_pkg::ST_IDLE) && out_free;
  assign in_fire   = in_tvalid && in_tready;

  // new value of a cell from its final neighbor count
  assign is_full = (rd_data_r == full_v);
  assign cnt_fin = cnt_r + 5'(is_full);
  always_comb begin
    nv = hp_r;
    if (hp_r > 4'd0 && hp_r < full_v) begin
      nv = hp_r - 4'd1;
    end else if (hp_r == full_v && !survival_r[cnt_fin]) begin
      nv = hp_r - 4'd1;
    end else if (hp_r == 4'd0 && spawn_r[cnt_fin]) begin
      nv = full_v;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    clr_addr_nxt   = clr_addr_r;
    cx_nxt         = cx_r;
    cy_nxt         = cy_r;
    cz_nxt         = cz_r;
    dx_nxt         = dx_r;
    dy_nxt         = dy_r;
    dz_nxt         = dz_r;
    tag_valid_nxt  = 1'b0;
    tag_first_nxt  = (dx_r == 2'd0) && (dy_r == 2'd0) && (dz_r == 2'd0);
    tag_center_nxt = (dx_r == 2'd1) && (dy_r == 2'd1) && (dz_r == 2'd1);
    tag_last_nxt   = last_k;
    tag_addr_nxt   = cell_addr_c;
    cp_valid_nxt   = 1'b0;
    cp_addr_nxt    = cell_addr_c;
    out_load       = 1'b0;
    out_health_nxt = 4'd0;
    out_done_nxt   = 1'b0;
    out_oor_nxt    = 1'b0;
    cm_re          = 1'b0;
    cm_raddr       = pos_addr;
    cm_we          = 1'b0;
    cm_waddr       = pos_addr;
    cm_wdata       = health_clamp;
    nm_re          = 1'b0;
    nm_raddr       = cell_addr_c;
    unique case (state_r)
      ca3d_pkg::ST_CLEAR: begin
        cm_we    = 1'b1;
        cm_waddr = clr_addr_r;
        cm_wdata = 4'd0;
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (clr_addr_r == AW'(DEPTH - 1)) begin
          state_nxt = ca3d_pkg::ST_IDLE;
        end
      end
      ca3d_pkg::ST_IDLE: begin
        cx_nxt = '0;
        cy_nxt = '0;
        cz_nxt = '0;
        dx_nxt = '0;
        dy_nxt = '0;
        dz_nxt = '0;
        if (in_fire) begin
          unique case (op)
            ca3d_pkg::OP_WRITE: begin
              out_load    = 1'b1;
              out_oor_nxt = oor;
              cm_we       = !oor;
            end
            ca3d_pkg::OP_READ: begin
              if (oor) begin
                out_load    = 1'b1;
                out_oor_nxt = 1'b1;
              end else begin
                cm_re     = 1'b1;
                state_nxt = ca3d_pkg::ST_RDWAIT;
              end
            end
            ca3d_pkg::OP_STEP: begin
              state_nxt = ca3d_pkg::ST_STEP;
            end
            default: begin
            end
          endcase
        end
      end
      ca3d_pkg::ST_RDWAIT: begin
        if (out_free) begin
          out_load       = 1'b1;
          out_health_nxt = rd_data_r;
          state_nxt      = ca3d_pkg::ST_IDLE;
        end
      end
      ca3d_pkg::ST_STEP: begin
        cm_re         = 1'b1;
        cm_raddr      = nb_addr;
        tag_valid_nxt = 1'b1;
        dz_nxt = (dz_r == 2'd2) ? 2'd0 : dz_r + 2'd1;
        if (dz_r == 2'd2) begin
          dy_nxt = (dy_r == 2'd2) ? 2'd0 : dy_r + 2'd1;
          if (dy_r == 2'd2) begin
            dx_nxt = (dx_r == 2'd2) ? 2'd0 : dx_r + 2'd1;
          end
        end
        if (last_k) begin
          cx_nxt = (cx_r == smax) ? '0 : cx_r + 1'b1;
          if (cx_r == smax) begin
            cy_nxt = (cy_r == smax) ? '0 : cy_r + 1'b1;
            if (cy_r == smax) begin
              cz_nxt = (cz_r == smax) ? '0 : cz_r + 1'b1;
            end
          end
          if (last_cell) begin
            state_nxt = ca3d_pkg::ST_STEP_DRAIN;
          end
        end
      end
      ca3d_pkg::ST_STEP_DRAIN: begin
        state_nxt = ca3d_pkg::ST_COPY;
      end
      ca3d_pkg::ST_COPY: begin
        nm_re        = 1'b1;
        cp_valid_nxt = 1'b1;
        cx_nxt = (cx_r == smax) ? '0 : cx_r + 1'b1;
        if (cx_r == smax) begin
          cy_nxt = (cy_r == smax) ? '0 : cy_r + 1'b1;
          if (cy_r == smax) begin
            cz_nxt = (cz_r == smax) ? '0 : cz_r + 1'b1;
          end
        end
        if (last_cell) begin
          state_nxt = ca3d_pkg::ST_COPY_DRAIN;
        end
      end
      ca3d_pkg::ST_COPY_DRAIN: begin
        state_nxt = ca3d_pkg::ST_FINISH;
      end
      ca3d_pkg::ST_FINISH: begin
        if (out_free) begin
          out_load     = 1'b1;
          out_done_nxt = 1'b1;
          state_nxt    = ca3d_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = ca3d_pkg::ST_IDLE;
      end
    endcase
    // copy write-back of the previous cycle's scratch read
    if (cp_valid_r) begin
      cm_we    = 1'b1;
      cm_waddr = cp_addr_r;
      cm_wdata = nx_data_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ca3d_pkg::ST_CLEAR;
      clr_addr_r   <= '0;
      tag_valid_r  <= 1'b0;
      cp_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      num_states_r <= ca3d_pkg::NUM_STATES_RST;
      survival_r   <= ca3d_pkg::SURVIVAL_RST;
      spawn_r      <= ca3d_pkg::SPAWN_RST;
      grid_side_r  <= ca3d_pkg::GRID_SIDE_RST;
      cx_r <= '0;
      cy_r <= '0;
      cz_r <= '0;
      dx_r <= '0;
      dy_r <= '0;
      dz_r <= '0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      tag_valid_r <= tag_valid_nxt;
      cp_valid_r  <= cp_valid_nxt;
      cx_r <= cx_nxt;
      cy_r <= cy_nxt;
      cz_r <= cz_nxt;
      dx_r <= dx_nxt;
      dy_r <= dy_nxt;
      dz_r <= dz_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          ca3d_pkg::REG_NUM_STATES: num_states_r <= cfg_data[4:0];
          ca3d_pkg::REG_SURVIVAL:   survival_r   <= cfg_data;
          ca3d_pkg::REG_SPAWN:      spawn_r      <= cfg_data;
          ca3d_pkg::REG_GRID_SIDE:  grid_side_r  <= cfg_data[4:0];
          default: begin
          end
        endcase
      end
    end
  end

  // payload registers and neighbor count
  always_ff @(posedge clk) begin
    tag_first_r  <= tag_first_nxt;
    tag_center_r <= tag_center_nxt;
    tag_last_r   <= tag_last_nxt;
    tag_addr_r   <= tag_addr_nxt;
    cp_addr_r    <= cp_addr_nxt;
    if (out_load) begin
      out_health_r <= out_health_nxt;
      out_done_r   <= out_done_nxt;
      out_oor_r    <= out_oor_nxt;
    end
    if (tag_valid_r) begin
      if (tag_first_r) begin
        cnt_r <= 5'(is_full);
      end else if (!tag_center_r) begin
        cnt_r <= cnt_fin;
      end
      if (tag_center_r) begin
        hp_r <= rd_data_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cm_we) begin
      cell_mem[cm_waddr] <= cm_wdata;
    end
    if (cm_re) begin
      rd_data_r <= cell_mem[cm_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (tag_valid_r && tag_last_r) begin
      next_mem[tag_addr_r] <= nv;
    end
    if (nm_re) begin
      nx_data_r <= next_mem[nm_raddr];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'd0, out_health_r};
  assign out_tuser  = {out_oor_r, out_done_r};

endmodule

// ----- src/ca3d_checker.sv -----
// port-level checks for cellular_automaton_3d_step, bound to the top level
// no dependencies
module ca3d_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tready,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic [1:0] out_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  a_step_not_oor: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tuser[0] && out_tuser[1]))
    else $error("step result flagged out of range");

  a_flag_zero_health: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser[0] || out_tuser[1]) |-> out_tdata == 8'd0)
    else $error("nonzero health on step or out-of-range result");

  a_no_accept_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !in_tready)
    else $error("input ready while result register stays full");

endmodule

bind cellular_automaton_3d_step ca3d_checker u_ca3d_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
